// File: hdl/gmd_pkg.sv
`timescale 1ns / 1ps

package gmd_pkg;

   localparam int FUNC_W     = 2;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int PATH_IDX_W = 12;
   localparam int STATUS_W   = 3;
   localparam int PATH_LEN_W = 13;
   localparam int CFG_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CMP_W      = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_SOLVE = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND   = 3'd0,
      ST_NO_PATH = 3'd1,
      ST_BAD_END = 3'd2,
      ST_LOADED  = 3'd3,
      ST_READ    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_WAIT,
      S_HOLD,
      S_CLEAR,
      S_CHK_START,
      S_START_W,
      S_END_W,
      S_VISIT,
      S_PROBE,
      S_PROBE_W,
      S_POP_W
   } state_type;

   typedef struct packed {
      logic       load_wall;
      logic       capture;
      logic       rd_path;
      logic       clr_step;
      logic       rd_start;
      logic       rd_end;
      logic       push_start;
      logic       mark;
      logic       probe;
      logic       push_nb;
      logic       next_dir;
      logic       pop;
      logic       load_top;
      logic       emit;
      status_type kind;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic clr_last;
      logic start_ok;
      logic end_ok;
      logic at_end;
      logic nb_inside;
      logic nb_free;
      logic dir_last;
      logic sp_one;
      logic sp_full;
   } sts_type;

endpackage

// File: hdl/gmd_if.sv
`timescale 1ns / 1ps

interface gmd_req_if
   import gmd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [ROW_W-1:0]      cell_row;
   logic [COL_W-1:0]      cell_col;
   logic                  wall;
   logic [ROW_W-1:0]      start_row;
   logic [COL_W-1:0]      start_col;
   logic [ROW_W-1:0]      end_row;
   logic [COL_W-1:0]      end_col;
   logic [PATH_IDX_W-1:0] path_index;

   modport source (
      output valid, func, cell_row, cell_col, wall, start_row, start_col,
             end_row, end_col, path_index,
      input  ready
   );
   modport sink (
      input  valid, func, cell_row, cell_col, wall, start_row, start_col,
             end_row, end_col, path_index,
      output ready
   );
endinterface

interface gmd_rsp_if
   import gmd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [PATH_LEN_W-1:0] path_length;
   logic [ROW_W-1:0]      path_row;
   logic [COL_W-1:0]      path_col;

   modport source (
      output valid, status, path_length, path_row, path_col,
      input  ready
   );
   modport sink (
      input  valid, status, path_length, path_row, path_col,
      output ready
   );
endinterface

// File: hdl/gmd_ctrl.sv
`timescale 1ns / 1ps

module gmd_ctrl
   import gmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   input  sts_type           sts,
   output cmd_type           cmd
);

   state_type  state_ff, state_in;
   status_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= ST_LOADED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.kind  = kind_ff;
      state_in  = state_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (func_type'(req_func))
                  FUNC_LOAD: begin
                     cmd.load_wall = 1'b1;
                     if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.kind = ST_LOADED;
                     end else begin
                        kind_in  = ST_LOADED;
                        state_in = S_HOLD;
                     end
                  end
                  FUNC_SOLVE: begin
                     cmd.capture = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  FUNC_READ: begin
                     cmd.rd_path = 1'b1;
                     state_in    = S_RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = ST_READ;
               state_in = S_IDLE;
            end else begin
               kind_in  = ST_READ;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_CHK_START;
         end
         S_CHK_START: begin
            cmd.rd_start = 1'b1;
            state_in     = S_START_W;
         end
         S_START_W: begin
            if (!sts.start_ok) begin
               kind_in  = ST_BAD_END;
               state_in = S_HOLD;
            end else begin
               cmd.rd_end = 1'b1;
               state_in   = S_END_W;
            end
         end
         S_END_W: begin
            if (!sts.end_ok) begin
               kind_in  = ST_BAD_END;
               state_in = S_HOLD;
            end else begin
               cmd.push_start = 1'b1;
               state_in       = S_VISIT;
            end
         end
         S_VISIT: begin
            if (sts.at_end) begin
               kind_in  = ST_FOUND;
               state_in = S_HOLD;
            end else begin
               cmd.mark = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (sts.nb_inside) begin
               cmd.probe = 1'b1;
               state_in  = S_PROBE_W;
            end else if (!sts.dir_last) begin
               cmd.next_dir = 1'b1;
            end else begin
               cmd.pop = 1'b1;
               if (sts.sp_one) begin
                  kind_in  = ST_NO_PATH;
                  state_in = S_HOLD;
               end else begin
                  state_in = S_POP_W;
               end
            end
         end
         S_PROBE_W: begin
            if (sts.nb_free && !sts.sp_full) begin
               cmd.push_nb = 1'b1;
               state_in    = S_VISIT;
            end else if (!sts.nb_free && !sts.dir_last) begin
               cmd.next_dir = 1'b1;
               state_in     = S_PROBE;
            end else begin
               cmd.pop = 1'b1;
               if (sts.sp_one) begin
                  kind_in  = ST_NO_PATH;
                  state_in = S_HOLD;
               end else begin
                  state_in = S_POP_W;
               end
            end
         end
         S_POP_W: begin
            cmd.load_top = 1'b1;
            state_in     = S_VISIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: hdl/gmd_dp.sv
`timescale 1ns / 1ps

module gmd_dp
   import gmd_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic [ROW_W-1:0]      req_cell_row,
   input  logic [COL_W-1:0]      req_cell_col,
   input  logic                  req_wall,
   input  logic [ROW_W-1:0]      req_start_row,
   input  logic [COL_W-1:0]      req_start_col,
   input  logic [ROW_W-1:0]      req_end_row,
   input  logic [COL_W-1:0]      req_end_col,
   input  logic [PATH_IDX_W-1:0] req_path_index,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PATH_LEN_W-1:0] rsp_path_length,
   output logic [ROW_W-1:0]      rsp_path_row,
   output logic [COL_W-1:0]      rsp_path_col
);

   localparam int RB          = $clog2(MAX_ROWS);
   localparam int CB          = $clog2(MAX_COLS);
   localparam int RW1         = RB + 1;
   localparam int CW1         = CB + 1;
   localparam int MW          = RB + CB;
   localparam int MAP_DEPTH   = 1 << MW;
   localparam int STACK_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int SA          = $clog2(STACK_DEPTH);
   localparam int SPW         = $clog2(STACK_DEPTH + 1);
   localparam int KW          = (SPW > PATH_IDX_W) ? SPW : PATH_IDX_W;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   logic [CFG_W-1:0]      row_count_ff, row_count_in;
   logic [CFG_W-1:0]      col_count_ff, col_count_in;
   logic [ROW_W-1:0]      start_r_ff, end_r_ff;
   logic [COL_W-1:0]      start_c_ff, end_c_ff;
   logic [RB-1:0]         cur_r_ff, cur_r_in;
   logic [CB-1:0]         cur_c_ff, cur_c_in;
   logic [SPW-1:0]        sp_ff, sp_in;
   dir_type               dir_ff, dir_in;
   logic [MW-1:0]         clr_ff, clr_in;
   logic                  k_ok_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [PATH_LEN_W-1:0] rsp_len_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic [COL_W-1:0]      rsp_col_ff;

   logic                  wall_ram [MAP_DEPTH];
   logic                  vis_ram [MAP_DEPTH];
   logic [MW-1:0]         stack_ram [STACK_DEPTH];
   logic                  wall_rd_ff;
   logic                  vis_rd_ff;
   logic [MW-1:0]         stack_rd_ff;

   logic [RW1-1:0]        rows_eff;
   logic [CW1-1:0]        cols_eff;
   logic [RW1-1:0]        nb_r;
   logic [CW1-1:0]        nb_c;
   logic                  nb_dir_ok;
   logic [MW-1:0]         nb_addr;
   logic [MW-1:0]         cur_addr;
   logic [MW-1:0]         start_addr;
   logic [MW-1:0]         end_addr;
   logic [MW-1:0]         load_addr;
   logic                  load_ok;
   logic                  start_in;
   logic                  end_in;
   logic                  wall_re;
   logic [MW-1:0]         wall_raddr;
   logic                  vis_we;
   logic [MW-1:0]         vis_waddr;
   logic                  stack_we;
   logic [SA-1:0]         stack_waddr;
   logic [MW-1:0]         stack_wdata;
   logic                  stack_re;
   logic [SA-1:0]         stack_raddr;
   logic [SPW-1:0]        sp_less2;

   // configuration registers
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate grid size to 1..max
   always_comb begin
      if (row_count_ff == '0)
         rows_eff = RW1'(1);
      else if (int'(row_count_ff) > MAX_ROWS)
         rows_eff = RW1'(MAX_ROWS);
      else
         rows_eff = RW1'(row_count_ff);
      if (col_count_ff == '0)
         cols_eff = CW1'(1);
      else if (int'(col_count_ff) > MAX_COLS)
         cols_eff = CW1'(MAX_COLS);
      else
         cols_eff = CW1'(col_count_ff);
   end

   // neighbor of the top cell in the current direction
   always_comb begin
      nb_r      = {1'b0, cur_r_ff};
      nb_c      = {1'b0, cur_c_ff};
      nb_dir_ok = 1'b1;
      case (dir_ff)
         DIR_RIGHT: nb_c = {1'b0, cur_c_ff} + CW1'(1);
         DIR_DOWN:  nb_r = {1'b0, cur_r_ff} + RW1'(1);
         DIR_LEFT: begin
            nb_dir_ok = (cur_c_ff != '0);
            nb_c      = {1'b0, cur_c_ff} - CW1'(1);
         end
         DIR_UP: begin
            nb_dir_ok = (cur_r_ff != '0);
            nb_r      = {1'b0, cur_r_ff} - RW1'(1);
         end
         default: nb_dir_ok = 1'b0;
      endcase
   end

   assign nb_addr    = {nb_r[RB-1:0], nb_c[CB-1:0]};
   assign cur_addr   = {cur_r_ff, cur_c_ff};
   assign start_addr = {RB'(start_r_ff), CB'(start_c_ff)};
   assign end_addr   = {RB'(end_r_ff), CB'(end_c_ff)};
   assign load_addr  = {RB'(req_cell_row), CB'(req_cell_col)};
   assign load_ok    = (int'(req_cell_row) < MAX_ROWS) && (int'(req_cell_col) < MAX_COLS);
   assign start_in   = (CMP_W'(start_r_ff) < CMP_W'(rows_eff))
                    && (CMP_W'(start_c_ff) < CMP_W'(cols_eff));
   assign end_in     = (CMP_W'(end_r_ff) < CMP_W'(rows_eff))
                    && (CMP_W'(end_c_ff) < CMP_W'(cols_eff));

   // wall map
   assign wall_re = cmd.rd_start | cmd.rd_end | cmd.probe;
   always_comb begin
      if (cmd.rd_start)
         wall_raddr = start_addr;
      else if (cmd.rd_end)
         wall_raddr = end_addr;
      else
         wall_raddr = nb_addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wall && load_ok) wall_ram[load_addr] <= req_wall;
      if (wall_re) wall_rd_ff <= wall_ram[wall_raddr];
   end

   // visited map
   assign vis_we    = cmd.clr_step | cmd.mark;
   assign vis_waddr = cmd.clr_step ? clr_ff : cur_addr;

   always_ff @(posedge clock) begin
      if (vis_we) vis_ram[vis_waddr] <= cmd.mark;
      if (cmd.probe) vis_rd_ff <= vis_ram[nb_addr];
   end

   // path stack
   assign sp_less2    = sp_ff - SPW'(2);
   assign stack_we    = cmd.push_start | cmd.push_nb;
   assign stack_waddr = cmd.push_start ? '0 : sp_ff[SA-1:0];
   assign stack_wdata = cmd.push_start ? start_addr : nb_addr;
   assign stack_re    = cmd.rd_path | cmd.pop;
   assign stack_raddr = cmd.rd_path ? SA'(req_path_index) : sp_less2[SA-1:0];

   always_ff @(posedge clock) begin
      if (stack_we) stack_ram[stack_waddr] <= stack_wdata;
      if (stack_re) stack_rd_ff <= stack_ram[stack_raddr];
   end

   // search registers
   always_comb begin
      sp_in    = sp_ff;
      cur_r_in = cur_r_ff;
      cur_c_in = cur_c_ff;
      dir_in   = dir_ff;
      clr_in   = clr_ff;
      if (cmd.capture) begin
         sp_in  = '0;
         clr_in = '0;
      end
      if (cmd.clr_step) clr_in = clr_ff + MW'(1);
      if (cmd.push_start) begin
         sp_in    = SPW'(1);
         cur_r_in = RB'(start_r_ff);
         cur_c_in = CB'(start_c_ff);
      end
      if (cmd.push_nb) begin
         sp_in    = sp_ff + SPW'(1);
         cur_r_in = nb_r[RB-1:0];
         cur_c_in = nb_c[CB-1:0];
      end
      if (cmd.pop) sp_in = sp_ff - SPW'(1);
      if (cmd.load_top) begin
         cur_r_in = stack_rd_ff[MW-1:CB];
         cur_c_in = stack_rd_ff[CB-1:0];
      end
      if (cmd.mark) dir_in = DIR_RIGHT;
      if (cmd.next_dir) dir_in = dir_type'(dir_ff + 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_RESET;
         col_count_ff <= CFG_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      dir_ff   <= dir_in;
      clr_ff   <= clr_in;
      if (cmd.capture) begin
         start_r_ff <= req_start_row;
         start_c_ff <= req_start_col;
         end_r_ff   <= req_end_row;
         end_c_ff   <= req_end_col;
      end
      if (cmd.rd_path) k_ok_ff <= (KW'(req_path_index) < KW'(sp_ff));
   end

   // output word register
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.kind;
         if (cmd.kind == ST_FOUND || cmd.kind == ST_READ)
            rsp_len_ff <= PATH_LEN_W'(sp_ff);
         else
            rsp_len_ff <= '0;
         if (cmd.kind == ST_READ && k_ok_ff) begin
            rsp_row_ff <= ROW_W'(stack_rd_ff[MW-1:CB]);
            rsp_col_ff <= COL_W'(stack_rd_ff[CB-1:0]);
         end else begin
            rsp_row_ff <= '0;
            rsp_col_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_path_row    = rsp_row_ff;
   assign rsp_path_col    = rsp_col_ff;

   // status to controller
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;
   assign sts.clr_last  = (clr_ff == '1);
   assign sts.start_ok  = start_in & ~wall_rd_ff;
   assign sts.end_ok    = end_in & ~wall_rd_ff;
   assign sts.at_end    = (CMP_W'(cur_r_ff) == CMP_W'(end_r_ff))
                       && (CMP_W'(cur_c_ff) == CMP_W'(end_c_ff));
   assign sts.nb_inside = nb_dir_ok && (nb_r < rows_eff) && (nb_c < cols_eff);
   assign sts.nb_free   = ~wall_rd_ff & ~vis_rd_ff;
   assign sts.dir_last  = (dir_ff == DIR_UP);
   assign sts.sp_one    = (sp_ff == SPW'(1));
   assign sts.sp_full   = (sp_ff == SPW'(STACK_DEPTH));

endmodule

// File: hdl/grid_maze_dfs_path_search.sv
`timescale 1ns / 1ps
// Maze path search by depth-first search over a stored grid of wall bits.
// req_bus carries one word per command: load (write one wall bit), solve
// (search from start to end cell) or read (return one cell of the last path).
// rsp_bus returns one word per command; function code 3 is dropped silently.
// csr_* writes row_count and col_count; the user must do so only while the
// block is idle, which the block itself does not enforce.
// Command flow:
//   load  - the word is registered when accepted if the output is free, else
//           once the stalled word leaves; one load per cycle while it is free
//   read  - stack entry read, then word registered; no new command meanwhile
//   solve - first a sweep clearing the visited map, one entry per cycle, over
//           2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries, 4096 by default,
//           then the endpoint checks, then each search step visits the top
//           cell, tries each direction and pops at a dead end, then emits
// A finished word sits in the output register; the next command is accepted
// while it waits, and a stalled receiver only holds the block once a second
// result is ready. Reset empties the stack, sets both sizes to 64 and drops
// any pending word; the wall map keeps whatever it held.
module grid_maze_dfs_path_search
   import gmd_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   gmd_req_if.sink              req_bus,
   gmd_rsp_if.source            rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   gmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gmd_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cell_row    (req_bus.cell_row),
      .req_cell_col    (req_bus.cell_col),
      .req_wall        (req_bus.wall),
      .req_start_row   (req_bus.start_row),
      .req_start_col   (req_bus.start_col),
      .req_end_row     (req_bus.end_row),
      .req_end_col     (req_bus.end_col),
      .req_path_index  (req_bus.path_index),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_path_length (rsp_bus.path_length),
      .rsp_path_row    (rsp_bus.path_row),
      .rsp_path_col    (rsp_bus.path_col)
   );

endmodule

// File: hdl/gmd_chk.sv
`timescale 1ns / 1ps

module gmd_chk
   import gmd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [FUNC_W-1:0]     req_func,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [PATH_LEN_W-1:0] rsp_path_length,
   input logic [ROW_W-1:0]      rsp_path_row,
   input logic [COL_W-1:0]      rsp_path_col
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_path_length) && $stable(rsp_path_row) && $stable(rsp_path_col))
      else $error("result word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_load_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LOADED |->
         rsp_path_length == '0 && rsp_path_row == '0 && rsp_path_col == '0)
      else $error("load word carries nonzero fields");

   a_fail_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_PATH || rsp_status == ST_BAD_END) |->
         rsp_path_length == '0)
      else $error("failed search reports a path length");

   a_load_turn: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_LOAD && (!rsp_valid || rsp_ready)
         |=> rsp_valid && rsp_status == ST_LOADED)
      else $error("load word not returned in one cycle");

endmodule

bind grid_maze_dfs_path_search gmd_chk u_gmd_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_func        (req_bus.func),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_path_length (rsp_bus.path_length),
   .rsp_path_row    (rsp_bus.path_row),
   .rsp_path_col    (rsp_bus.path_col)
);
